FILE: sv/pdl_pkg.sv
// ----------------------------------------------------------------------------
// pdl_pkg: shared types and constants of the positional delete list
// Field widths, command and status codes, and the per-slot control bundle.
// ----------------------------------------------------------------------------
package pdl_pkg;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 16;
	localparam int LEN_W    = 5;
	localparam int STATUS_W = 2;

	// Command codes carried in the input tuser
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// Result status codes carried in the output tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Per-slot control: load the appended value, take the neighbor's value,
	// or expose the held value on the removal tap
	typedef struct packed {
		logic load;
		logic shift;
		logic tap;
	} slot_ctl_t;

endpackage

FILE: sv/positional_delete_list_top.sv
// A result is registered and appears on the output in the cycle after its request is taken.
// Throughput: one request per cycle while the output is not held; the list slots update in the accept cycle.
// A request is taken while the output register is empty or being drained.
// Reset (arst_n low) empties the list and drops any pending result.
// Slot contents are not reset; slots beyond the length are never read.
// ----------------------------------------------------------------------------
// positional_delete_list_top: bounded list with append and positional delete
// Appends at the tail, deletes at a 1-based position closing the gap, and
// reports status, removed value and new length for every request.
// ----------------------------------------------------------------------------
module positional_delete_list_top #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [31:0] value, [47:32] position
	input  logic [0:0]  s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] removed_value, [36:32] length, rest zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

	logic                                accept;
	logic                                cmd;
	logic signed [pdl_pkg::VALUE_W-1:0]  in_value;
	logic [pdl_pkg::POS_W-1:0]           position;
	logic                                append_ok;
	logic                                delete_ok;
	pdl_pkg::status_t                    status;
	logic [CNT_W-1:0]                    count_q;
	logic [CNT_W-1:0]                    count_next;
	logic signed [pdl_pkg::VALUE_W-1:0]  removed;

	logic                                m_valid_q;
	pdl_pkg::status_t                    m_status_q;
	logic signed [pdl_pkg::VALUE_W-1:0]  m_removed_q;
	logic [pdl_pkg::LEN_W-1:0]           m_length_q;

	assign cmd      = s_tuser[0];
	assign in_value = s_tdata[31:0];
	assign position = s_tdata[47:32];
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Classify the request and compute the new length
	always_comb begin
		append_ok  = 1'b0;
		delete_ok  = 1'b0;
		status     = pdl_pkg::ST_OK;
		count_next = count_q;
		if (cmd == pdl_pkg::CMD_APPEND) begin
			if (count_q == CapCount) begin
				status = pdl_pkg::ST_FULL;
			end else begin
				append_ok  = accept;
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (count_q == '0) begin
				status = pdl_pkg::ST_EMPTY;
			end else if (position == '0 || position > pdl_pkg::POS_W'(count_q)) begin
				status = pdl_pkg::ST_BADPOS;
			end else begin
				delete_ok  = accept;
				count_next = count_q - CNT_W'(1);
			end
		end
	end

	pdl_chain #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_chain (
		.clk       (clk),
		.append_ok (append_ok),
		.delete_ok (delete_ok),
		.count     (count_q),
		.position  (position),
		.in_value  (in_value),
		.removed   (removed)
	);

	// Advance the length on each taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_status_q  <= status;
			m_removed_q <= removed;
			m_length_q  <= pdl_pkg::LEN_W'(count_next);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_length_q, m_removed_q};
	assign m_tuser  = m_status_q;

	// Length never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CapCount)
		else $error("list length above capacity");

	// An append into a list with room grows it by one
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == pdl_pkg::CMD_APPEND && count_q != CapCount
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not grow the list");

	// A valid delete yields an ok result in the following cycle
	a_delete_ok: assert property (@(posedge clk) disable iff (!arst_n)
		delete_ok |=> m_tvalid && m_tuser == pdl_pkg::ST_OK)
		else $error("delete result missing or not ok");

	// The length only moves on a taken request
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("length changed without a request");

endmodule

FILE: sv/pdl_cell.sv
// ----------------------------------------------------------------------------
// pdl_cell: one storage slot of the list
// Holds one element; loads an appended value or takes its upper neighbor's
// value when the list closes a gap, and drives its value onto the removal tap.
// ----------------------------------------------------------------------------
module pdl_cell (
	input  logic                                clk,
	input  pdl_pkg::slot_ctl_t                  ctl,
	input  logic signed [pdl_pkg::VALUE_W-1:0]  in_value,
	input  logic signed [pdl_pkg::VALUE_W-1:0]  next_value,
	output logic signed [pdl_pkg::VALUE_W-1:0]  value,
	output logic signed [pdl_pkg::VALUE_W-1:0]  tap_value
);

	logic signed [pdl_pkg::VALUE_W-1:0] value_q;

	// Load on append, shift down on delete, hold otherwise
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= in_value;
		end else if (ctl.shift) begin
			value_q <= next_value;
		end
	end

	assign value     = value_q;
	assign tap_value = ctl.tap ? value_q : '0;

endmodule

FILE: sv/pdl_chain.sv
// ----------------------------------------------------------------------------
// pdl_chain: row of storage slots
// Decodes the request into per-slot controls, links each slot to its upper
// neighbor and gathers the removed element from the slot taps.
// ----------------------------------------------------------------------------
module pdl_chain #(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  logic                                append_ok,
	input  logic                                delete_ok,
	input  logic [CNT_W-1:0]                    count,
	input  logic [pdl_pkg::POS_W-1:0]           position,
	input  logic signed [pdl_pkg::VALUE_W-1:0]  in_value,
	output logic signed [pdl_pkg::VALUE_W-1:0]  removed
);

	logic signed [pdl_pkg::VALUE_W-1:0] slot_value [CAPACITY];
	logic signed [pdl_pkg::VALUE_W-1:0] slot_tap   [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		localparam logic [CNT_W-1:0]          SlotIdx = CNT_W'(i);
		localparam logic [pdl_pkg::POS_W-1:0] SlotPos = pdl_pkg::POS_W'(i + 1);

		pdl_pkg::slot_ctl_t                 ctl;
		logic signed [pdl_pkg::VALUE_W-1:0] next_value;

		// Append writes the first free slot; delete shifts every slot from the
		// removed position upward and taps the removed one
		always_comb begin
			ctl.load  = append_ok && (count == SlotIdx);
			ctl.shift = delete_ok && (SlotPos >= position);
			ctl.tap   = delete_ok && (SlotPos == position);
		end

		if (i == CAPACITY - 1) begin : g_top
			assign next_value = slot_value[i];
		end else begin : g_mid
			assign next_value = slot_value[i+1];
		end

		pdl_cell u_slot (
			.clk        (clk),
			.ctl        (ctl),
			.in_value   (in_value),
			.next_value (next_value),
			.value      (slot_value[i]),
			.tap_value  (slot_tap[i])
		);
	end

	// Merge the taps; at most one is nonzero
	always_comb begin
		removed = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			removed = removed | slot_tap[k];
		end
	end

endmodule

FILE: dv/tb_positional_delete_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_delete_list_top: self-checking bench for the delete list
// Drives append and delete requests through the input stream, predicts each
// result from a shadow copy of the list, and compares status, removed value
// and length of every result under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_positional_delete_list_top;

	localparam int LIST_DEPTH = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 450;

	typedef struct packed {
		pdl_pkg::status_t               status;
		logic signed [31:0]             removed;
		logic [pdl_pkg::LEN_W-1:0]      length;
	} list_result_t;

	// Shadow list and queue of predicted results
	class list_scoreboard;
		logic [pdl_pkg::VALUE_W-1:0] cells [LIST_DEPTH];
		int unsigned                 count;
		list_result_t                expected_q [$];
		int unsigned                 mismatches;

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Apply one accepted request to the shadow list and queue its result
		function void note_request(logic cmd, logic [pdl_pkg::VALUE_W-1:0] value,
				logic [pdl_pkg::POS_W-1:0] pos);
			list_result_t res;
			res.status  = pdl_pkg::ST_OK;
			res.removed = '0;
			if (cmd == pdl_pkg::CMD_APPEND) begin
				if (count >= LIST_DEPTH) begin
					res.status = pdl_pkg::ST_FULL;
				end else begin
					cells[count] = value;
					count++;
				end
			end else if (count == 0) begin
				res.status = pdl_pkg::ST_EMPTY;
			end else if (pos < 1 || pos > count) begin
				res.status = pdl_pkg::ST_BADPOS;
			end else begin
				res.removed = cells[pos-1];
				for (int unsigned i = pos - 1; i + 1 < count; i++)
					cells[i] = cells[i+1];
				count--;
			end
			res.length = count[pdl_pkg::LEN_W-1:0];
			expected_q.push_back(res);
		endfunction

		// Compare one delivered result against the oldest prediction
		function void check_result(logic [pdl_pkg::STATUS_W-1:0] status,
				logic [pdl_pkg::VALUE_W-1:0] removed, logic [pdl_pkg::LEN_W-1:0] length,
				logic [2:0] pad);
			list_result_t exp_res;
			if (expected_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result status=%0d removed=%0d length=%0d",
						$realtime, status, $signed(removed), length);
				mismatches++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (status !== exp_res.status || removed !== exp_res.removed ||
					length !== exp_res.length || pad !== 3'b000) begin
				if (mismatches < 10)
					$display("%0t: mismatch exp status=%0d removed=%0d length=%0d,",
						$realtime, exp_res.status, exp_res.removed, exp_res.length,
						" got status=%0d removed=%0d length=%0d pad=%b",
						status, $signed(removed), length, pad);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // [31:0] value, [47:32] position
	logic [0:0]  s_tuser = '0;   // [0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [31:0] removed_value, [36:32] length
	logic [1:0]  m_tuser;        // [1:0] status

	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	int unsigned quiet_cycles = 0;
	list_scoreboard sb;

	positional_delete_list_top #(.CAPACITY(LIST_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	// Note accepted requests, check accepted results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser[0], s_tdata[31:0], s_tdata[47:32]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata[31:0], m_tdata[36:32], m_tdata[39:37]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("positional_delete_list_top verification failed");
				$finish;
			end
		end
	end

	// Offer one request and hold it until taken; enter and leave at a falling edge
	task automatic send(logic cmd, logic [pdl_pkg::VALUE_W-1:0] value,
			logic [pdl_pkg::POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pos, value};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every predicted result has come back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	function automatic logic [pdl_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(19))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Mostly valid positions, some zero, some past the tail, some anywhere
	function automatic logic [pdl_pkg::POS_W-1:0] pick_position(int unsigned held);
		int unsigned r;
		r = $urandom_range(99);
		if (held > 0 && r < 75)
			return pdl_pkg::POS_W'($urandom_range(held, 1));
		if (r < 83)
			return '0;
		if (r < 93)
			return pdl_pkg::POS_W'($urandom_range(LIST_DEPTH + 1, held + 1));
		return pdl_pkg::POS_W'($urandom);
	endfunction

	// Random traffic; the append share swings so the list runs empty and full
	task automatic run_random(int unsigned n);
		int unsigned append_pct;
		append_pct = 50;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0:       append_pct = 15;
					1:       append_pct = 50;
					default: append_pct = 85;
				endcase
			end
			if ($urandom_range(99) < append_pct)
				send(pdl_pkg::CMD_APPEND, pick_value(), pdl_pkg::POS_W'($urandom));
			else
				send(pdl_pkg::CMD_DELETE, $urandom, pick_position(sb.count));
		end
	endtask

	initial begin
		sb = new;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty deletes, extreme values, bad positions, gap closing, full
		send(pdl_pkg::CMD_DELETE, 32'h1234_5678, 16'd1);
		send(pdl_pkg::CMD_DELETE, 32'h0, 16'd0);
		send(pdl_pkg::CMD_APPEND, 32'h7fff_ffff, 16'hffff);
		send(pdl_pkg::CMD_APPEND, 32'h8000_0000, 16'h0);
		send(pdl_pkg::CMD_APPEND, 32'h0000_0000, 16'd1);
		send(pdl_pkg::CMD_APPEND, 32'hffff_ffff, 16'd2);
		send(pdl_pkg::CMD_DELETE, 32'h0, 16'd0);
		send(pdl_pkg::CMD_DELETE, 32'h0, 16'd5);
		send(pdl_pkg::CMD_DELETE, 32'hffff_ffff, 16'hffff);
		send(pdl_pkg::CMD_DELETE, 32'h0, 16'd2);
		send(pdl_pkg::CMD_DELETE, 32'h0, 16'd3);
		for (int k = 0; k < LIST_DEPTH - 2; k++)
			send(pdl_pkg::CMD_APPEND, $urandom, 16'h0);
		send(pdl_pkg::CMD_APPEND, 32'h5555_aaaa, 16'h0);
		send(pdl_pkg::CMD_DELETE, 32'h0, 16'd16);
		send(pdl_pkg::CMD_DELETE, 32'h0, 16'd1);
		wait_drain();

		// Random phases: no idling, sender idle, receiver stall, both
		send_idle = 0;  recv_stall = 0;
		run_random(ITEMS_PER_PHASE);
		wait_drain();
		send_idle = 56; recv_stall = 0;
		run_random(ITEMS_PER_PHASE);
		wait_drain();
		send_idle = 0;  recv_stall = 56;
		run_random(ITEMS_PER_PHASE);
		wait_drain();
		send_idle = 15; recv_stall = 15;
		run_random(ITEMS_PER_PHASE);
		wait_drain();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("positional_delete_list_top verification clean");
		else
			$display("positional_delete_list_top verification failed");
		$finish;
	end

endmodule
